### rtl/tcaa_pkg.sv
// Package for the two-channel ADC block averager.
// Field widths, register indexes, command and status types, and the count clamp.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcaa_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int MAX_AVERAGE_DEF = 2000;

    localparam int CNT_W    = 11;
    localparam int SUM_W    = 21;
    localparam int AVG_W    = 14;
    localparam int NUM_W    = 16;
    localparam int PHY_W    = 4;
    localparam int MAXAVG_W = 17;
    localparam int IDX_W    = 2;
    localparam int CFG_W    = CNT_W;

    // average = (20*sum + n) / (2*n)
    localparam int NUMER_W  = SUM_W + 5;
    localparam int DEN_W    = CNT_W + 1;
    localparam int STEP_W   = $clog2(NUMER_W);

    localparam logic [IDX_W-1:0] REG_COUNT0 = 2'd0;
    localparam logic [IDX_W-1:0] REG_COUNT1 = 2'd1;
    localparam logic [IDX_W-1:0] REG_PHYS0  = 2'd2;
    localparam logic [IDX_W-1:0] REG_PHYS1  = 2'd3;

    typedef struct packed {
        logic accept;
        logic load_plain;
        logic start_div;
        logic load_done;
    } t_cmd;

    typedef struct packed {
        logic complete;
        logic out_free;
        logic div_done;
    } t_stat;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                     input logic [MAXAVG_W-1:0] max_avg);
        logic [CNT_W-1:0] res;
        res = c;
        if (c == '0) begin
            res = CNT_W'(1);
        end else if (MAXAVG_W'(c) > max_avg) begin
            res = max_avg[CNT_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/tcaa_if.sv
// Word channels of the two-channel ADC block averager: sample in, result out.
// Depends on tcaa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tcaa_in_if #(
    parameter int SAMPLE_BITS = tcaa_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tcaa_out_if;
    logic                            valid;
    logic                            ready;
    logic                            done_res;
    logic                            chan;
    logic [tcaa_pkg::SUM_W-1:0]      block_sum;
    logic [tcaa_pkg::CNT_W-1:0]      block_count;
    logic [tcaa_pkg::AVG_W-1:0]      average_tenths;
    logic [tcaa_pkg::NUM_W-1:0]      result_number;
    logic [tcaa_pkg::PHY_W-1:0]      next_input;

    modport source (output valid, output done_res, output chan, output block_sum,
                    output block_count, output average_tenths, output result_number,
                    output next_input, input ready);
    modport sink   (input valid, input done_res, input chan, input block_sum,
                    input block_count, input average_tenths, input result_number,
                    input next_input, output ready);
endinterface

`default_nettype wire

### rtl/two_channel_adc_averager.sv
// Top level of the two-channel ADC block averager.
// Depends on tcaa_pkg, tcaa_if, tcaa_ctrl and tcaa_dp.
//
// One conversion word in gives one result word out. Samples add up on the current
// logical channel until its count (clamped to 1..MAX_AVERAGE) is reached; that word
// gives a done result with sum, count, average in tenths rounded half up and the
// channel's wrapping result number, and the block moves to the other channel.
// Every result names the physical input to convert next. A word that does not
// finish a block is accepted and its result loaded in the same cycle; a word that
// does is accepted, then starts the 26-step restoring divider for the tenths
// average; the result loads once the divider is done and the output is free.
// A result word that waits holds off the next input word; the next word may enter
// in the cycle the waiting result is taken.
// Configuration is taken in any cycle and should be written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module two_channel_adc_averager #(
    parameter int SAMPLE_BITS = tcaa_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_AVERAGE = tcaa_pkg::MAX_AVERAGE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [tcaa_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [tcaa_pkg::CFG_W-1:0]    i_cfg_data,
    tcaa_in_if.sink                            i_in,
    tcaa_out_if.source                         o_out
);
    tcaa_pkg::t_cmd  w_cmd;
    tcaa_pkg::t_stat w_stat;
    logic            w_ready;

    tcaa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tcaa_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_AVERAGE (MAX_AVERAGE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_in.sample[SAMPLE_BITS-1:0]),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out      (o_out)
    );

    assign i_in.ready = w_ready;

endmodule

`default_nettype wire

### rtl/tcaa_div.sv
// Restoring divider, one quotient bit per cycle, for the tenths average.
// Depends on tcaa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcaa_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tcaa_pkg::NUMER_W-1:0]  i_numer,
    input  wire logic [tcaa_pkg::DEN_W-1:0]    i_denom,
    output logic      [tcaa_pkg::AVG_W-1:0]    o_quot,
    output logic                               o_done
);
    localparam int NW = tcaa_pkg::NUMER_W;
    localparam int DW = tcaa_pkg::DEN_W;
    localparam int SW = tcaa_pkg::STEP_W;
    localparam logic [SW-1:0] LAST_STEP = SW'(NW - 1);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_q;
    logic [SW-1:0] r_step;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   w_trial;
    logic [DW-1:0] w_diff;
    logic          w_ge;
    logic [DW-1:0] n_rem;

    assign w_trial = {r_rem, r_q[NW-1]};
    assign w_diff  = DW'(w_trial - {1'b0, r_den});
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign n_rem   = w_ge ? w_diff : w_trial[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + SW'(1);
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_denom;
            r_q   <= i_numer;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[NW-2:0], w_ge};
        end
    end

    assign o_quot = r_q[tcaa_pkg::AVG_W-1:0];
    assign o_done = r_done;

endmodule

`default_nettype wire

### rtl/tcaa_dp.sv
// Datapath of the block averager: configuration, running sum and count,
// per-channel result numbers, divider operands and the result register.
// Depends on tcaa_pkg, tcaa_if and tcaa_div.
`timescale 1ns / 1ps
`default_nettype none

module tcaa_dp #(
    parameter int SAMPLE_BITS = tcaa_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_AVERAGE = tcaa_pkg::MAX_AVERAGE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [tcaa_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [tcaa_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic [SAMPLE_BITS-1:0]        i_sample,
    input  wire tcaa_pkg::t_cmd                i_cmd,
    output tcaa_pkg::t_stat                    o_stat,
    tcaa_out_if.source                         o_out
);
    localparam int CW = tcaa_pkg::CNT_W;
    localparam int SW = tcaa_pkg::SUM_W;
    localparam int NW = tcaa_pkg::NUMER_W;

    logic [CW-1:0]              r_cnt0;
    logic [CW-1:0]              r_cnt1;
    logic [tcaa_pkg::PHY_W-1:0] r_phy0;
    logic [tcaa_pkg::PHY_W-1:0] r_phy1;

    logic                       r_chan;
    logic [SW-1:0]              r_sum;
    logic [CW-1:0]              r_count;
    logic [tcaa_pkg::NUM_W-1:0] r_blk [2];

    logic                       r_res_chan;
    logic [SW-1:0]              r_res_sum;
    logic [CW-1:0]              r_res_cnt;
    logic [tcaa_pkg::NUM_W-1:0] r_res_num;

    logic                       r_out_valid;
    logic                       r_o_done;
    logic                       r_o_chan;
    logic [SW-1:0]              r_o_sum;
    logic [CW-1:0]              r_o_cnt;
    logic [tcaa_pkg::AVG_W-1:0] r_o_avg;
    logic [tcaa_pkg::NUM_W-1:0] r_o_num;
    logic [tcaa_pkg::PHY_W-1:0] r_o_phy;

    logic [CW-1:0]              w_limit;
    logic [SW-1:0]              n_sum;
    logic [CW-1:0]              n_count;
    logic [tcaa_pkg::NUM_W-1:0] n_blk;
    logic                       w_complete;
    logic [NW-1:0]              w_numer;
    logic [tcaa_pkg::DEN_W-1:0] w_denom;
    logic [tcaa_pkg::AVG_W-1:0] w_quot;
    logic                       w_div_done;
    logic [tcaa_pkg::PHY_W-1:0] w_phy_cur;

    assign w_limit    = tcaa_pkg::clamp_count(r_chan ? r_cnt1 : r_cnt0,
                                              tcaa_pkg::MAXAVG_W'(MAX_AVERAGE));
    assign n_sum      = r_sum + {{(SW-SAMPLE_BITS){1'b0}}, i_sample};
    assign n_count    = r_count + CW'(1);
    assign w_complete = (n_count >= w_limit);
    assign n_blk      = r_blk[r_chan] + tcaa_pkg::NUM_W'(1);
    assign w_phy_cur  = r_chan ? r_phy1 : r_phy0;

    assign w_numer = NW'({r_res_sum, 4'b0000}) + NW'({r_res_sum, 2'b00}) + NW'(r_res_cnt);
    assign w_denom = {r_res_cnt, 1'b0};

    tcaa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_div),
        .i_numer (w_numer),
        .i_denom (w_denom),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt0 <= CW'(1);
            r_cnt1 <= CW'(1);
            r_phy0 <= '0;
            r_phy1 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tcaa_pkg::REG_COUNT0: r_cnt0 <= i_cfg_data;
                tcaa_pkg::REG_COUNT1: r_cnt1 <= i_cfg_data;
                tcaa_pkg::REG_PHYS0:  r_phy0 <= i_cfg_data[tcaa_pkg::PHY_W-1:0];
                tcaa_pkg::REG_PHYS1:  r_phy1 <= i_cfg_data[tcaa_pkg::PHY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan   <= 1'b0;
            r_sum    <= '0;
            r_count  <= '0;
            r_blk[0] <= '0;
            r_blk[1] <= '0;
        end else if (i_cmd.accept) begin
            if (w_complete) begin
                r_sum         <= '0;
                r_count       <= '0;
                r_chan        <= ~r_chan;
                r_blk[r_chan] <= n_blk;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_complete) begin
            r_res_chan <= r_chan;
            r_res_sum  <= n_sum;
            r_res_cnt  <= n_count;
            r_res_num  <= n_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_plain || i_cmd.load_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_plain) begin
            r_o_done <= 1'b0;
            r_o_chan <= 1'b0;
            r_o_sum  <= '0;
            r_o_cnt  <= '0;
            r_o_avg  <= '0;
            r_o_num  <= '0;
            r_o_phy  <= w_phy_cur;
        end else if (i_cmd.load_done) begin
            r_o_done <= 1'b1;
            r_o_chan <= r_res_chan;
            r_o_sum  <= r_res_sum;
            r_o_cnt  <= r_res_cnt;
            r_o_avg  <= w_quot;
            r_o_num  <= r_res_num;
            r_o_phy  <= w_phy_cur;
        end
    end

    assign o_stat.complete = w_complete;
    assign o_stat.out_free = ~r_out_valid | o_out.ready;
    assign o_stat.div_done = w_div_done;

    assign o_out.valid          = r_out_valid;
    assign o_out.done_res       = r_o_done;
    assign o_out.chan           = r_o_chan;
    assign o_out.block_sum      = r_o_sum;
    assign o_out.block_count    = r_o_cnt;
    assign o_out.average_tenths = r_o_avg;
    assign o_out.result_number  = r_o_num;
    assign o_out.next_input     = r_o_phy;

endmodule

`default_nettype wire

### rtl/tcaa_ctrl.sv
// Controller of the block averager: sequences accept, division and result load.
// Depends on tcaa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcaa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire tcaa_pkg::t_stat i_stat,
    output tcaa_pkg::t_cmd       o_cmd
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_ready;
    logic       w_accept;

    assign w_ready  = (r_state == ST_IDLE) && i_stat.out_free;
    assign w_accept = w_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_stat.complete) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready       = w_ready;
    assign o_cmd.accept     = w_accept;
    assign o_cmd.load_plain = w_accept && !i_stat.complete;
    assign o_cmd.start_div  = (r_state == ST_START);
    assign o_cmd.load_done  = (r_state == ST_OUT) && i_stat.out_free;

endmodule

`default_nettype wire
